[rtl/ksa_pkg.sv]
// Shared types, constants and scan code tables for the scan code to ASCII decoder.
package ksa_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [7:0] LED_CMD_RESET = 8'hED;

	localparam logic [7:0] SC_BACKSPACE = 8'h0E;
	localparam logic [7:0] SC_ENTER     = 8'h1C;
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_NUM       = 8'h45;
	localparam logic [7:0] SC_SCROLL    = 8'h46;
	localparam logic [7:0] SC_ACK       = 8'hFA;
	localparam logic [7:0] SC_RESEND    = 8'hFE;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [7:0] ASCII_BS     = 8'h08;
	localparam logic [7:0] ASCII_LF     = 8'h0A;

	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_LED  = 2'd1,
		KIND_KBD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} entry_t;

	function automatic logic [7:0] plain_char(input logic [6:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (idx)
			7'h02: c = 8'h31;
			7'h03: c = 8'h32;
			7'h04: c = 8'h33;
			7'h05: c = 8'h34;
			7'h06: c = 8'h35;
			7'h07: c = 8'h36;
			7'h08: c = 8'h37;
			7'h09: c = 8'h38;
			7'h0A: c = 8'h39;
			7'h0B: c = 8'h30;
			7'h0C: c = 8'h2D;
			7'h0D: c = 8'h3D;
			7'h10: c = 8'h51;
			7'h11: c = 8'h57;
			7'h12: c = 8'h45;
			7'h13: c = 8'h52;
			7'h14: c = 8'h54;
			7'h15: c = 8'h59;
			7'h16: c = 8'h55;
			7'h17: c = 8'h49;
			7'h18: c = 8'h4F;
			7'h19: c = 8'h50;
			7'h1A: c = 8'h5B;
			7'h1B: c = 8'h5D;
			7'h1E: c = 8'h41;
			7'h1F: c = 8'h53;
			7'h20: c = 8'h44;
			7'h21: c = 8'h46;
			7'h22: c = 8'h47;
			7'h23: c = 8'h48;
			7'h24: c = 8'h4A;
			7'h25: c = 8'h4B;
			7'h26: c = 8'h4C;
			7'h27: c = 8'h3B;
			7'h28: c = 8'h27;
			7'h29: c = 8'h60;
			7'h2B: c = 8'h5C;
			7'h2C: c = 8'h5A;
			7'h2D: c = 8'h58;
			7'h2E: c = 8'h43;
			7'h2F: c = 8'h56;
			7'h30: c = 8'h42;
			7'h31: c = 8'h4E;
			7'h32: c = 8'h4D;
			7'h33: c = 8'h2C;
			7'h34: c = 8'h2E;
			7'h35: c = 8'h2F;
			7'h37: c = 8'h2A;
			7'h39: c = 8'h20;
			7'h47: c = 8'h37;
			7'h48: c = 8'h38;
			7'h49: c = 8'h39;
			7'h4A: c = 8'h2D;
			7'h4B: c = 8'h34;
			7'h4C: c = 8'h35;
			7'h4D: c = 8'h36;
			7'h4E: c = 8'h2B;
			7'h4F: c = 8'h31;
			7'h50: c = 8'h32;
			7'h51: c = 8'h33;
			7'h52: c = 8'h30;
			7'h53: c = 8'h2E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shifted_char(input logic [6:0] idx);
		logic [7:0] c;
		c = plain_char(idx);
		unique case (idx)
			7'h02: c = 8'h21;
			7'h03: c = 8'h40;
			7'h04: c = 8'h23;
			7'h05: c = 8'h24;
			7'h06: c = 8'h25;
			7'h07: c = 8'h5E;
			7'h08: c = 8'h26;
			7'h09: c = 8'h2A;
			7'h0A: c = 8'h28;
			7'h0B: c = 8'h29;
			7'h0C: c = 8'h5F;
			7'h0D: c = 8'h2B;
			7'h1A: c = 8'h7B;
			7'h1B: c = 8'h7D;
			7'h27: c = 8'h3A;
			7'h28: c = 8'h22;
			7'h29: c = 8'h7E;
			7'h2B: c = 8'h7C;
			7'h33: c = 8'h3C;
			7'h34: c = 8'h3E;
			7'h35: c = 8'h3F;
			default: ;
		endcase
		return c;
	endfunction

endpackage

[rtl/ksa_front.sv]
// Front end: accepts scan codes, keeps shift/lock/ack state, classifies into queue entries.
module ksa_front
	import ksa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic       ack_wait_q;
	logic [7:0] last_cmd_q;

	logic       take;
	logic [7:0] ch_raw;
	logic [7:0] ch;
	logic       has_result;
	logic [2:0] toggle;
	logic [2:0] leds_nxt;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign leds_nxt = leds_q ^ toggle;

	always_comb begin
		ch_raw = 8'h00;
		if (!scan_code[7]) begin
			ch_raw = (shift_q == 2'b00) ? plain_char(scan_code[6:0])
			                            : shifted_char(scan_code[6:0]);
		end
		ch = ch_raw;
		if (ch_raw >= 8'h41 && ch_raw <= 8'h5A) begin
			if (leds_q[2] == (shift_q != 2'b00)) ch = ch_raw + CASE_OFFSET;
		end
	end

	always_comb begin
		has_result = 1'b0;
		toggle     = 3'b000;
		q_entry    = '{kind: KIND_CHAR, value: ch};
		if (ch != 8'h00) begin
			has_result = 1'b1;
		end else begin
			unique case (scan_code) inside
				SC_BACKSPACE: begin
					has_result    = 1'b1;
					q_entry.value = ASCII_BS;
				end
				SC_ENTER: begin
					has_result    = 1'b1;
					q_entry.value = ASCII_LF;
				end
				SC_CAPS, SC_NUM, SC_SCROLL: begin
					has_result = 1'b1;
					if (scan_code == SC_CAPS) toggle = LED_CAPS;
					else if (scan_code == SC_NUM) toggle = LED_NUM;
					else toggle = LED_SCROLL;
					q_entry = '{kind: KIND_LED, value: {5'b00000, leds_q ^ toggle}};
				end
				SC_RESEND: begin
					has_result = ack_wait_q;
					q_entry    = '{kind: KIND_KBD, value: last_cmd_q};
				end
				default: ;
			endcase
		end
	end

	assign q_push = take && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= 2'b00;
			leds_q     <= 3'b000;
			ack_wait_q <= 1'b0;
			last_cmd_q <= 8'h00;
		end else if (take && ch == 8'h00) begin
			case (scan_code) inside
				SC_LSHIFT:    shift_q <= shift_q | 2'b01;
				SC_RSHIFT:    shift_q <= shift_q | 2'b10;
				SC_LSHIFT_UP: shift_q <= shift_q & 2'b10;
				SC_RSHIFT_UP: shift_q <= shift_q & 2'b01;
				SC_ACK:       ack_wait_q <= 1'b0;
				SC_CAPS, SC_NUM, SC_SCROLL: begin
					leds_q     <= leds_nxt;
					last_cmd_q <= {5'b00000, leds_nxt};
					ack_wait_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/ksa_queue.sv]
// Small register queue between front and back ends.
module ksa_queue
	import ksa_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/ksa_back.sv]
// Back end: expands queue entries into result items and holds the output register.
module ksa_back
	import ksa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       q_empty,
	input  entry_t     q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       dest,
	output logic [7:0] value,
	output logic       last
);

	logic [7:0] led_cmd_q;
	logic       out_valid_q;
	logic       dest_q;
	logic [7:0] value_q;
	logic       last_q;
	logic       second_q;
	logic [7:0] led_val_q;
	logic       load;

	assign out_valid = out_valid_q;
	assign dest      = dest_q;
	assign value     = value_q;
	assign last      = last_q;
	assign load      = !out_valid_q || out_ready;
	assign q_pop     = load && !second_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_cmd_q <= LED_CMD_RESET;
		end else if (cfg_wr_en) begin
			led_cmd_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				second_q    <= !q_empty && (q_head.kind == KIND_LED);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				dest_q  <= 1'b1;
				value_q <= led_val_q;
				last_q  <= 1'b1;
			end else if (!q_empty) begin
				led_val_q <= q_head.value;
				unique case (q_head.kind)
					KIND_CHAR: begin
						dest_q  <= 1'b0;
						value_q <= q_head.value;
						last_q  <= 1'b1;
					end
					KIND_LED: begin
						dest_q  <= 1'b1;
						value_q <= led_cmd_q;
						last_q  <= 1'b0;
					end
					KIND_KBD: begin
						dest_q  <= 1'b1;
						value_q <= q_head.value;
						last_q  <= 1'b1;
					end
					default: begin
						dest_q  <= 1'b0;
						value_q <= q_head.value;
						last_q  <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule

[rtl/keyboard_scancode_to_ascii.sv]
// Top level of the set-1 scan code to ASCII decoder.
//
// Input channel: in_valid/in_ready with one scan code byte per item.
// Output channel: out_valid/out_ready; each item carries dest (0 = character
// for the application, 1 = byte for the keyboard), value and last, which marks
// the final result of an input item. Codes that give no result emit nothing.
// Config: cfg_wr_en/cfg_wr_data write the LED command byte (reset 0xED).
// Path: each entry is written into the queue and then into the output register,
// from which the receiver accepts its results.
// Input: one scan code per cycle while the queue is not full; a lock key
// occupies the single output register for two results (command byte, then LED
// value), and results leave at one per cycle while out_ready is high. A resend
// emits the last LED value while an ack is outstanding.
// Reset clears the shift, lock LED and ack state and empties the queue.
// When the receiver stalls, results wait in the output register and entries
// collect in the queue; in_ready drops once the queue is full.
module keyboard_scancode_to_ascii
	import ksa_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       dest,
	output logic [7:0] value,
	output logic       last
);

	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	entry_t q_entry;
	entry_t q_head;

	ksa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.scan_code (scan_code),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	ksa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	ksa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest        (dest),
		.value       (value),
		.last        (last)
	);

endmodule

[sim/keyboard_scancode_to_ascii_tb.sv]
// Self-checking testbench for the set-1 scan code to ASCII decoder.
`timescale 1ns / 100ps

module keyboard_scancode_to_ascii_tb;
	import ksa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS = 10;
	localparam logic DEST_APP = 1'b0;
	localparam logic DEST_KBD = 1'b1;
	localparam logic [7:0] NO_CHAR = "x";

	typedef struct packed {
		logic       dest;
		logic [7:0] value;
		logic       last;
	} key_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] scan_code = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       dest;
	logic [7:0] value;
	logic       last;

	// decoder state as the testbench sees it
	logic [1:0] shift_held = 2'b00;
	logic [2:0] lock_leds = 3'b000;
	logic       awaiting_ack = 1'b0;
	logic [7:0] resend_byte = 8'h00;
	logic [7:0] led_cmd = LED_CMD_RESET;

	logic [7:0]  pending_codes[$];
	key_result_t expected_keys[$];
	key_result_t got;
	key_result_t want;
	int          items_in_flight = 0;
	int          mismatches = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	keyboard_scancode_to_ascii DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.scan_code   (scan_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest        (dest),
		.value       (value),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] lookup_char(input logic [6:0] idx, input logic shifted);
		string      row;
		logic [7:0] c;
		if (shifted) begin
			row = {"xx!@#$%^&*()_+xxQWERTYUIOP{}xxAS",
				"DFGHJKL:\"~x|ZXCVBNM<>?x*x xxxxxx",
				"xxxxxxx789-456+1230."};
		end else begin
			row = {"xx1234567890-=xxQWERTYUIOP[]xxAS",
				"DFGHJKL;'`x\\ZXCVBNM,./x*x xxxxxx",
				"xxxxxxx789-456+1230."};
		end
		c = NO_CHAR;
		if (idx < row.len())
			c = row[idx];
		return (c == NO_CHAR) ? 8'h00 : c;
	endfunction

	function automatic void decode_scan(input logic [7:0] code);
		logic [7:0] ch;
		logic [2:0] toggle;
		logic       shifted;
		ch = 8'h00;
		toggle = 3'b000;
		shifted = (shift_held != 2'b00);
		if (code < 8'h80)
			ch = lookup_char(code[6:0], shifted);
		if (ch >= "A" && ch <= "Z" && (((lock_leds & LED_CAPS) != 3'b000) == shifted))
			ch = ch + CASE_OFFSET;
		if (ch != 8'h00) begin
			expected_keys.push_back(key_result_t'{DEST_APP, ch, 1'b1});
			return;
		end
		case (code)
			SC_BACKSPACE: expected_keys.push_back(key_result_t'{DEST_APP, ASCII_BS, 1'b1});
			SC_ENTER:     expected_keys.push_back(key_result_t'{DEST_APP, ASCII_LF, 1'b1});
			SC_LSHIFT:    shift_held[0] = 1'b1;
			SC_RSHIFT:    shift_held[1] = 1'b1;
			SC_LSHIFT_UP: shift_held[0] = 1'b0;
			SC_RSHIFT_UP: shift_held[1] = 1'b0;
			SC_CAPS:      toggle = LED_CAPS;
			SC_NUM:       toggle = LED_NUM;
			SC_SCROLL:    toggle = LED_SCROLL;
			SC_ACK:       awaiting_ack = 1'b0;
			SC_RESEND: begin
				if (awaiting_ack)
					expected_keys.push_back(key_result_t'{DEST_KBD, resend_byte, 1'b1});
			end
			default: ;
		endcase
		if (toggle != 3'b000) begin
			lock_leds = lock_leds ^ toggle;
			expected_keys.push_back(key_result_t'{DEST_KBD, led_cmd, 1'b0});
			expected_keys.push_back(key_result_t'{DEST_KBD, {5'b00000, lock_leds}, 1'b1});
			resend_byte = {5'b00000, lock_leds};
			awaiting_ack = 1'b1;
		end
	endfunction

	function automatic logic [7:0] random_scan();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return 8'($urandom_range(8'h53));
		if (pick < 60) begin
			case ($urandom_range(3))
				0: return SC_LSHIFT;
				1: return SC_RSHIFT;
				2: return SC_LSHIFT_UP;
				default: return SC_RSHIFT_UP;
			endcase
		end
		if (pick < 70) begin
			case ($urandom_range(2))
				0: return SC_CAPS;
				1: return SC_NUM;
				default: return SC_SCROLL;
			endcase
		end
		if (pick < 78)
			return SC_ACK;
		if (pick < 86)
			return SC_RESEND;
		return 8'($urandom_range(255));
	endfunction

	task automatic queue_scan(input logic [7:0] code);
		pending_codes.push_back(code);
		items_in_flight++;
	endtask

	task automatic wait_drained();
		while (items_in_flight != 0 || expected_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_led_cmd(input logic [7:0] code);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		led_cmd = code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input key_result_t exp_k,
		input key_result_t act_k);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"ERROR %0t: %s exp dest=%0d value=%02h last=%0d,",
				" got dest=%0d value=%02h last=%0d"},
				$time, what, exp_k.dest, exp_k.value, exp_k.last,
				act_k.dest, act_k.value, act_k.last);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			scan_code <= 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				decode_scan(scan_code);
				items_in_flight--;
			end
			if (!in_valid || in_ready) begin
				if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					scan_code <= pending_codes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = key_result_t'{dest, value, last};
				if (expected_keys.size() == 0) begin
					report_mismatch("unexpected item", key_result_t'(0), got);
				end else begin
					want = expected_keys.pop_front();
					if (got.dest !== want.dest || got.value !== want.value
						|| got.last !== want.last)
						report_mismatch("mismatch", want, got);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] directed[$];
		int         send_pcts[4];
		int         recv_pcts[4];
		logic [7:0] cfg_values[4];
		send_pcts = '{0, 54, 0, 31};
		recv_pcts = '{0, 0, 54, 31};
		cfg_values = '{8'h00, 8'hFF, 8'h00, LED_CMD_RESET};
		cfg_values[2] = 8'($urandom_range(255));
		directed = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h10, 8'h02, SC_BACKSPACE, SC_ENTER,
			SC_RESEND, SC_LSHIFT, 8'h10, 8'h02, SC_CAPS, 8'h10, SC_RESEND, SC_LSHIFT_UP,
			8'h10, SC_RSHIFT, 8'h35, SC_RSHIFT_UP, SC_NUM, SC_SCROLL, SC_ACK, SC_RESEND,
			8'h53};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			queue_scan(directed[i]);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			write_led_cmd(cfg_values[p]);
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2)
					wait_drained();
				queue_scan(random_scan());
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
